// ===== hdl/xor_checked_frame_parser_defines.svh =====
// Assertion helpers shared by the frame parser.
`ifndef XOR_CHECKED_FRAME_PARSER_DEFINES_SVH
`define XOR_CHECKED_FRAME_PARSER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define XFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Consequence in the cycle after the condition.
`define XFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ===== hdl/xfp_pkg.sv =====
package xfp_pkg;

  localparam logic [7:0] START_MARKER_RST = 8'h5B;
  localparam logic [7:0] END_MARKER_RST   = 8'h5D;
  localparam logic [3:0] ACK_CLASS_RST    = 4'hA;

  localparam int CFG_ADDR_W = 4;

  // register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_ACK_CLASS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_REQ_OK  = 3'd1,
    KIND_ACK_OK  = 3'd2,
    KIND_BAD_END = 3'd3,
    KIND_BAD_SUM = 3'd4
  } kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  cmd_type;
    logic [7:0]  cmd_param;
    logic [15:0] data_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  ack_code_high;
    logic [7:0]  ack_code_low;
  } out_item_t;

endpackage

// ===== hdl/xfp_if.sv =====
interface xfp_in_if;
  logic               valid;
  logic               ready;
  xfp_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xfp_out_if;
  logic               valid;
  logic               ready;
  xfp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/xor_checked_frame_parser.sv =====
// Frame parser for start-marker delimited frames, one byte per transaction.
// in_ch  : valid/ready channel; req_type 0 carries rx_byte, req_type 1 releases
//          a pending good request so that hunting for the next frame resumes.
// out_ch : valid/ready channel; zero or one result per input transaction
//          (payload byte, request ok, ack ok, bad end marker, bad checksum).
// cfg_*  : APB-style write/read port; start_marker at 0x0, end_marker at 0x4,
//          ack_class at 0x8. Write only while the parser is idle.
// Path:   an input transaction is registered in the input register at the
//          accept edge, parsed there once the result register is free or
//          being drained, and its result, if any, is then written to the
//          result register, which drives out_ch.valid and out_ch.data.
// Throughput: one byte per cycle unless stalled by out_ch.ready; the per-byte
//          work is an 8-bit XOR and a phase update between the two registers.
// Stall: the input register holds its transaction while the result register
//          is full and not taken; in_ch.ready drops only when both are full
//          and out_ch.ready is low.
// Reset (rst_n low, synchronous): registers return to their reset values,
//          the parser hunts for a start marker, no transaction is in flight.
`include "xor_checked_frame_parser_defines.svh"

module xor_checked_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  xfp_in_if.sink                          in_ch,
  xfp_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [xfp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_XOR,
    PH_END
  } phase_t;

  // configuration
  logic [7:0] start_r;
  logic [7:0] end_r;
  logic [3:0] ackc_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  param_r, param_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;

  // input register and result register
  xfp_pkg::in_item_t  s1_r;
  logic               s1_v_r, s1_v_nxt;
  xfp_pkg::out_item_t out_r, out_nxt;
  logic               out_v_r, out_v_nxt;

  logic        adv, in_fire, fire, emit, cfg_wr;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] cnt_inc;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      xfp_pkg::REG_START_MARKER: cfg_prdata = {24'd0, start_r};
      xfp_pkg::REG_END_MARKER:   cfg_prdata = {24'd0, end_r};
      xfp_pkg::REG_ACK_CLASS:    cfg_prdata = {28'd0, ackc_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= xfp_pkg::START_MARKER_RST;
      end_r   <= xfp_pkg::END_MARKER_RST;
      ackc_r  <= xfp_pkg::ACK_CLASS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        xfp_pkg::REG_START_MARKER: start_r <= cfg_pwdata[7:0];
        xfp_pkg::REG_END_MARKER:   end_r   <= cfg_pwdata[7:0];
        xfp_pkg::REG_ACK_CLASS:    ackc_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // The input register moves on whenever the result register is free or is
  // being drained this cycle.
  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign fire         = s1_v_r && adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  assign b       = s1_r.rx_byte;
  assign len     = {len_hi_r, len_lo_r};
  assign cnt_inc = cnt_r + 16'd1;

  // ------------------------------------------------------------ byte parse
  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    type_nxt    = type_r;
    param_nxt   = param_r;
    len_hi_nxt  = len_hi_r;
    len_lo_nxt  = len_lo_r;
    xor_nxt     = xor_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    emit        = 1'b0;
    out_nxt     = '0;

    if (fire) begin
      if (s1_r.req_type) begin
        // release: only acts on a pending request
        if (pend_r) begin
          pend_nxt    = 1'b0;
          phase_nxt   = PH_HUNT;
          hdr_pos_nxt = 3'd0;
          xor_nxt     = 8'd0;
          cnt_nxt     = 16'd0;
        end
      end else if (!pend_r) begin
        case (phase_r)
          PH_HUNT: begin
            if (b == start_r) begin
              phase_nxt   = PH_HEADER;
              hdr_pos_nxt = 3'd0;
              xor_nxt     = 8'd0;
              cnt_nxt     = 16'd0;
            end
          end
          PH_HEADER: begin
            if (hdr_pos_r < 3'd4) begin
              case (hdr_pos_r[1:0])
                2'd0:    type_nxt   = b;
                2'd1:    param_nxt  = b;
                2'd2:    len_hi_nxt = b;
                default: len_lo_nxt = b;
              endcase
              xor_nxt     = xor_r ^ b;
              hdr_pos_nxt = hdr_pos_r + 3'd1;
            end else begin
              hdr_pos_nxt = 3'd0;
              if (type_r[7:4] == ackc_r && b == end_r) begin
                // acknowledge: header bytes are type, code high, code low, xor
                emit                  = 1'b1;
                out_nxt.result_kind   = ((type_r ^ param_r ^ len_hi_r) == len_lo_r) ?
                                        xfp_pkg::KIND_ACK_OK : xfp_pkg::KIND_BAD_SUM;
                out_nxt.cmd_type      = type_r;
                out_nxt.ack_code_high = param_r;
                out_nxt.ack_code_low  = len_hi_r;
                phase_nxt             = PH_HUNT;
              end else begin
                xor_nxt = xor_r ^ b;
                if (len == 16'd0) begin
                  // empty payload: this byte was the checksum
                  phase_nxt = PH_END;
                end else begin
                  emit                  = 1'b1;
                  out_nxt.result_kind   = xfp_pkg::KIND_PAYLOAD;
                  out_nxt.cmd_type      = type_r;
                  out_nxt.cmd_param     = param_r;
                  out_nxt.data_length   = len;
                  out_nxt.payload_byte  = b;
                  out_nxt.payload_index = 16'd0;
                  cnt_nxt               = 16'd1;
                  phase_nxt             = (len == 16'd1) ? PH_XOR : PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            emit                  = 1'b1;
            out_nxt.result_kind   = xfp_pkg::KIND_PAYLOAD;
            out_nxt.cmd_type      = type_r;
            out_nxt.cmd_param     = param_r;
            out_nxt.data_length   = len;
            out_nxt.payload_byte  = b;
            out_nxt.payload_index = cnt_r;
            xor_nxt               = xor_r ^ b;
            cnt_nxt               = cnt_inc;
            if (cnt_inc >= len) begin
              phase_nxt = PH_XOR;
            end
          end
          PH_XOR: begin
            xor_nxt   = xor_r ^ b;
            phase_nxt = PH_END;
          end
          PH_END: begin
            emit                = 1'b1;
            phase_nxt           = PH_HUNT;
            out_nxt.cmd_type    = type_r;
            out_nxt.cmd_param   = param_r;
            out_nxt.data_length = len;
            if (b != end_r) begin
              out_nxt.result_kind = xfp_pkg::KIND_BAD_END;
            end else if (xor_r != 8'd0) begin
              out_nxt.result_kind = xfp_pkg::KIND_BAD_SUM;
            end else begin
              out_nxt.result_kind = xfp_pkg::KIND_REQ_OK;
              pend_nxt            = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    if (fire) begin
      out_v_nxt = emit;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_pos_r <= 3'd0;
      type_r    <= 8'd0;
      param_r   <= 8'd0;
      len_hi_r  <= 8'd0;
      len_lo_r  <= 8'd0;
      xor_r     <= 8'd0;
      cnt_r     <= 16'd0;
      pend_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      type_r    <= type_nxt;
      param_r   <= param_nxt;
      len_hi_r  <= len_hi_nxt;
      len_lo_r  <= len_lo_nxt;
      xor_r     <= xor_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
      // payload registers, no reset needed
      if (in_fire) begin
        s1_r <= in_ch.data;
      end
      if (fire && emit) begin
        out_r <= out_nxt;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  // A pending request is only ever set on the way back to hunting.
  `XFP_ASSERT_SAME(a_pend_in_hunt, pend_r, phase_r == PH_HUNT)
  // A good request result always leaves the parser blocked until release.
  `XFP_ASSERT_NEXT(a_ok_sets_pend, emit && out_nxt.result_kind == xfp_pkg::KIND_REQ_OK, pend_r)
  // Payload phase never runs past the announced length.
  `XFP_ASSERT_SAME(a_cnt_in_len, phase_r == PH_PAYLOAD, cnt_r < len)

endmodule

// ===== bench/tb_xor_checked_frame_parser.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the frame parser.
// A scoreboard object tracks the parser state, predicts the result of every
// accepted input transaction, and checks each result transaction in order.
module tb_xor_checked_frame_parser;

  // Where the parser is within a frame.
  typedef enum logic [2:0] {
    SEEK,     // hunting for the start marker
    HEADER,   // type, param, length high, length low, then the deciding byte
    PAYLOAD,  // payload bytes still to come
    CHECK,    // XOR byte
    TRAILER   // end marker
  } parse_phase_t;

  class frame_scoreboard;
    // register copies
    logic [7:0]   start_mk;
    logic [7:0]   end_mk;
    logic [3:0]   ack_cls;
    // parser state
    parse_phase_t phase;
    logic [2:0]   hdr_pos;
    logic [7:0]   f_type;
    logic [7:0]   f_param;
    logic [7:0]   len_hi;
    logic [7:0]   len_lo;
    logic [7:0]   xor_acc;
    logic [15:0]  rx_cnt;
    bit           pending;
    // results still owed by the parser, oldest first
    xfp_pkg::out_item_t expected_q[$];
    int           errors;
    int           live_items;
    int           longest;
    int           kind_cnt[5];

    function new();
      start_mk = xfp_pkg::START_MARKER_RST;
      end_mk   = xfp_pkg::END_MARKER_RST;
      ack_cls  = xfp_pkg::ACK_CLASS_RST;
      phase    = SEEK;
      hdr_pos  = '0;
      f_type   = '0;
      f_param  = '0;
      len_hi   = '0;
      len_lo   = '0;
      xor_acc  = '0;
      rx_cnt   = '0;
      pending  = 1'b0;
      errors   = 0;
      live_items = 0;
      longest  = 0;
      foreach (kind_cnt[k]) kind_cnt[k] = 0;
    endfunction

    function void set_reg(xfp_pkg::cfg_reg_t r, logic [7:0] v);
      case (r)
        xfp_pkg::REG_START_MARKER: start_mk = v;
        xfp_pkg::REG_END_MARKER:   end_mk = v;
        xfp_pkg::REG_ACK_CLASS:    ack_cls = v[3:0];
        default: ;
      endcase
    endfunction

    function xfp_pkg::out_item_t frame_fields(xfp_pkg::kind_t k);
      xfp_pkg::out_item_t r;
      r = '0;
      r.result_kind = k;
      r.cmd_type    = f_type;
      r.cmd_param   = f_param;
      r.data_length = {len_hi, len_lo};
      return r;
    endfunction

    // Advance the parser copy by one accepted input transaction.
    function void note_input(xfp_pkg::in_item_t it);
      xfp_pkg::out_item_t r;
      bit          emit;
      logic [7:0]  b;
      logic [15:0] len;
      r    = '0;
      emit = 1'b0;
      b    = it.rx_byte;
      if (it.req_type) begin
        // release only matters while a good request is held
        if (pending) begin
          pending = 1'b0;
          phase   = SEEK;
          hdr_pos = '0;
          xor_acc = '0;
          rx_cnt  = '0;
          live_items++;
        end
        return;
      end
      if (pending) return;
      live_items++;
      len = {len_hi, len_lo};
      case (phase)
        SEEK: begin
          if (b == start_mk) begin
            phase   = HEADER;
            hdr_pos = '0;
            xor_acc = '0;
            rx_cnt  = '0;
          end
        end
        HEADER: begin
          if (hdr_pos < 3'd4) begin
            case (hdr_pos)
              3'd0: f_type = b;
              3'd1: f_param = b;
              3'd2: len_hi = b;
              default: len_lo = b;
            endcase
            xor_acc ^= b;
            hdr_pos++;
          end else begin
            hdr_pos = '0;
            if (f_type[7:4] == ack_cls && b == end_mk) begin
              // ack: codes sit in param and length high, length low is the XOR
              r.result_kind   = ((f_type ^ f_param ^ len_hi) == len_lo) ?
                                xfp_pkg::KIND_ACK_OK : xfp_pkg::KIND_BAD_SUM;
              r.cmd_type      = f_type;
              r.ack_code_high = f_param;
              r.ack_code_low  = len_hi;
              emit  = 1'b1;
              phase = SEEK;
            end else begin
              xor_acc ^= b;
              if (len > longest) longest = len;
              if (len == 16'd0) begin
                phase = TRAILER;
              end else begin
                r = frame_fields(xfp_pkg::KIND_PAYLOAD);
                r.payload_byte  = b;
                r.payload_index = '0;
                rx_cnt = 16'd1;
                phase  = (len == 16'd1) ? CHECK : PAYLOAD;
                emit   = 1'b1;
              end
            end
          end
        end
        PAYLOAD: begin
          r = frame_fields(xfp_pkg::KIND_PAYLOAD);
          r.payload_byte  = b;
          r.payload_index = rx_cnt;
          xor_acc ^= b;
          rx_cnt++;
          if (rx_cnt >= len) phase = CHECK;
          emit = 1'b1;
        end
        CHECK: begin
          xor_acc ^= b;
          phase = TRAILER;
        end
        TRAILER: begin
          phase = SEEK;
          if (b != end_mk) begin
            r = frame_fields(xfp_pkg::KIND_BAD_END);
          end else if (xor_acc != 8'h00) begin
            r = frame_fields(xfp_pkg::KIND_BAD_SUM);
          end else begin
            r = frame_fields(xfp_pkg::KIND_REQ_OK);
            pending = 1'b1;
          end
          emit = 1'b1;
        end
        default: phase = SEEK;
      endcase
      if (emit) expected_q.push_back(r);
    endfunction

    function void diff(string field, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, e, a);
        errors++;
      end
    endfunction

    function void check_result(xfp_pkg::out_item_t got);
      xfp_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result_kind: expected no result, actual 0x%0h", got.result_kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      diff("result_kind", e.result_kind, got.result_kind);
      diff("cmd_type", e.cmd_type, got.cmd_type);
      diff("cmd_param", e.cmd_param, got.cmd_param);
      diff("data_length", e.data_length, got.data_length);
      diff("payload_byte", e.payload_byte, got.payload_byte);
      diff("payload_index", e.payload_index, got.payload_index);
      diff("ack_code_high", e.ack_code_high, got.ack_code_high);
      diff("ack_code_low", e.ack_code_low, got.ack_code_low);
      if (int'(e.result_kind) < 5) kind_cnt[int'(e.result_kind)]++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [xfp_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  xfp_in_if  in_if ();
  xfp_out_if out_if ();

  frame_scoreboard sb = new();

  bit in_idle_en;
  bit out_idle_en;
  int cfg_errors;
  int settings_used;

  xor_checked_frame_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: ready toggles at the falling edge, transactions are
  // checked at the rising edge on the values that stood before it.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = !out_idle_en || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  // Hard stop.
  initial begin
    #4_000_000;
    $error("run did not finish in time, %0d results outstanding",
           sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Drivers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------

  // One input transaction, with optional idle cycles ahead of it.
  task automatic send_item(input xfp_pkg::in_item_t it);
    while (in_idle_en && $urandom_range(99) < 18) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    xfp_pkg::in_item_t it;
    it.req_type = 1'b0;
    it.rx_byte  = b;
    send_item(it);
  endtask

  // rx_byte is don't-care on a release, so it carries noise
  task automatic send_release();
    xfp_pkg::in_item_t it;
    it.req_type = 1'b1;
    it.rx_byte  = 8'($urandom);
    send_item(it);
  endtask

  // Send a frame byte by byte; a stray release may be slipped in anywhere.
  task automatic push_frame(ref logic [7:0] q[$], input bit stray);
    int pos;
    pos = stray ? $urandom_range(q.size() - 1) : -1;
    foreach (q[i]) begin
      if (i == pos) send_release();
      send_byte(q[i]);
    end
  endtask

  // flaw: 0 good, 1 wrong XOR byte, 2 wrong end marker
  task automatic send_request(input logic [7:0] ty, input logic [7:0] pa,
                              input logic [15:0] len, input int flaw,
                              input bit stray);
    logic [7:0] q[$];
    logic [7:0] x;
    logic [7:0] pb;
    logic [7:0] ending;
    bit         ack_like;
    ack_like = (ty[7:4] == sb.ack_cls);
    x = ty ^ pa ^ len[15:8] ^ len[7:0];
    q = {sb.start_mk, ty, pa, len[15:8], len[7:0]};
    for (int i = 0; i < int'(len); i++) begin
      pb = 8'($urandom);
      // an ack-class type must not see the end marker as its deciding byte
      while (i == 0 && ack_like && pb == sb.end_mk) pb = 8'($urandom);
      x ^= pb;
      q.push_back(pb);
    end
    if (flaw == 1) x ^= 8'h01 << $urandom_range(7);
    if (len == 16'd0 && ack_like && x == sb.end_mk) begin
      q[2] ^= 8'h01;
      x ^= 8'h01;
    end
    q.push_back(x);
    ending = sb.end_mk;
    if (flaw == 2) ending ^= 8'h01 << $urandom_range(7);
    q.push_back(ending);
    push_frame(q, stray);
  endtask

  task automatic send_ack(input logic [3:0] sub, input logic [7:0] hi,
                          input logic [7:0] lo, input bit bad, input bit stray);
    logic [7:0] q[$];
    logic [7:0] ty;
    logic [7:0] x;
    ty = {sb.ack_cls, sub};
    x  = ty ^ hi ^ lo;
    if (bad) x ^= 8'h01 << $urandom_range(7);
    q = {sb.start_mk, ty, hi, lo, x, sb.end_mk};
    push_frame(q, stray);
  endtask

  // Bring the parser back to hunting with nothing held. Zero header bytes
  // keep an interrupted header from announcing a huge payload.
  task automatic resync();
    while (sb.pending || sb.phase != SEEK) begin
      if (sb.pending) send_release();
      else if (sb.phase == HEADER) send_byte(8'h00);
      else send_byte(8'($urandom));
    end
  endtask

  // Wait until every owed result has come, then let in-flight no-result
  // transactions drain.
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_access(input bit wr, input xfp_pkg::cfg_reg_t r,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Write all three registers (upper data bits are noise), then read back.
  task automatic apply_setting(input logic [7:0] sm, input logic [7:0] em,
                               input logic [3:0] ac);
    logic [7:0]  vals [3];
    logic [31:0] mask;
    logic [31:0] rd;
    xfp_pkg::cfg_reg_t r;
    wait_idle();
    vals[0] = sm;
    vals[1] = em;
    vals[2] = {4'h0, ac};
    for (int k = 0; k < 3; k++) begin
      r    = xfp_pkg::cfg_reg_t'(k);
      mask = (r == xfp_pkg::REG_ACK_CLASS) ? 32'h0000_000F : 32'h0000_00FF;
      cfg_access(1'b1, r, ($urandom & ~mask) | (32'(vals[k]) & mask), rd);
      sb.set_reg(r, vals[k]);
    end
    for (int k = 0; k < 3; k++) begin
      r    = xfp_pkg::cfg_reg_t'(k);
      mask = (r == xfp_pkg::REG_ACK_CLASS) ? 32'h0000_000F : 32'h0000_00FF;
      cfg_access(1'b0, r, 32'h0, rd);
      if ((rd & mask) !== (32'(vals[k]) & mask)) begin
        $error("%s readback: expected 0x%0h, actual 0x%0h",
               r.name(), 32'(vals[k]) & mask, rd & mask);
        cfg_errors++;
      end
    end
    settings_used++;
  endtask

  function automatic logic [7:0] rand_type();
    logic [7:0] t;
    t = 8'($urandom);
    if ($urandom_range(3) == 0) t[7:4] = sb.ack_cls;
    return t;
  endfunction

  // Mostly short payloads; a few cross into a nonzero length high byte.
  function automatic logic [15:0] rand_len();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 16'd0;
    if (p < 70) return 16'($urandom_range(4, 1));
    if (p < 95) return 16'($urandom_range(24, 5));
    return 16'($urandom_range(300, 25));
  endfunction

  // Mixed traffic until enough transactions have reached the parser.
  // Well-formed frames dominate; flawed frames, noise and cut-off headers fill the rest.
  task automatic run_mix(input int target);
    int         base;
    int         pick;
    int         n;
    logic [7:0] b;
    base = sb.live_items;
    while (sb.live_items - base < target) begin
      resync();
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request(rand_type(), 8'($urandom), rand_len(), 0,
                     $urandom_range(9) == 0);
        // held request: these bytes must be dropped
        n = $urandom_range(2);
        repeat (n) send_byte(8'($urandom));
        send_release();
      end else if (pick < 63) begin
        send_ack(4'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(3) == 0, $urandom_range(9) == 0);
      end else if (pick < 79) begin
        send_request(rand_type(), 8'($urandom), rand_len(), (pick < 71) ? 1 : 2,
                     $urandom_range(9) == 0);
      end else if (pick < 88) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            send_release();
          end else begin
            b = 8'($urandom);
            while (b == sb.start_mk) b = 8'($urandom);
            send_byte(b);
          end
        end
      end else if (pick < 94) begin
        // cut-off header; resync completes it with zeros
        send_byte(sb.start_mk);
        n = $urandom_range(2);
        repeat (n) send_byte(8'($urandom));
      end else begin
        send_request({sb.ack_cls, 4'($urandom)}, 8'($urandom), rand_len(), 0,
                     1'b0);
        send_release();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    rst_n         = 1'b0;
    in_idle_en    = 1'b1;
    out_idle_en   = 1'b1;
    cfg_errors    = 0;
    settings_used = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset register values.
    // Good ack with extreme codes, then an ack with a broken checksum.
    send_ack(4'hF, 8'h00, 8'hFF, 1'b0, 1'b0);
    send_ack(4'h0, 8'hFF, 8'h00, 1'b1, 1'b0);
    // Zero-length request whose type looks like an ack; the deciding byte is
    // the XOR, not the end marker. A release lands mid-header and is ignored.
    begin : zero_len_req
      logic [7:0] q[$];
      q = {xfp_pkg::START_MARKER_RST, 8'hA3, 8'h7E, 8'h00, 8'h00, 8'hDD,
           xfp_pkg::END_MARKER_RST};
      foreach (q[i]) begin
        if (i == 3) send_release();
        send_byte(q[i]);
      end
    end
    // Request held: even a start marker is dropped until the release.
    send_byte(xfp_pkg::START_MARKER_RST);
    send_release();
    // One payload byte, then a wrong end marker.
    send_request(8'hFF, 8'h00, 16'h0001, 2, 1'b0);

    // Long payload with both sides streaming: the no-idle stretch, with the
    // length and the payload index past one byte.
    wait_idle();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_request(8'($urandom), 8'($urandom), 16'd300, 0, 1'b0);
    send_release();
    wait_idle();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    run_mix(250);
    // extremes of every register
    apply_setting(8'h00, 8'hFF, 4'h0);
    run_mix(250);
    apply_setting(8'hFF, 8'h00, 4'hF);
    run_mix(250);
    // start and end markers share one value
    begin : same_markers
      logic [7:0] m;
      m = 8'($urandom);
      apply_setting(m, m, 4'($urandom));
    end
    run_mix(250);
    apply_setting(8'($urandom), 8'($urandom), 4'($urandom));
    run_mix(250);
    apply_setting(xfp_pkg::START_MARKER_RST, xfp_pkg::END_MARKER_RST,
                  xfp_pkg::ACK_CLASS_RST);
    run_mix(100);

    wait_idle();
    $display("Run: %0d parser transactions over %0d register settings, longest payload %0d",
             sb.live_items, settings_used + 1, sb.longest);
    $display("Results: payload %0d, request ok %0d, ack ok %0d, bad end %0d, bad sum %0d",
             sb.kind_cnt[xfp_pkg::KIND_PAYLOAD], sb.kind_cnt[xfp_pkg::KIND_REQ_OK],
             sb.kind_cnt[xfp_pkg::KIND_ACK_OK], sb.kind_cnt[xfp_pkg::KIND_BAD_END],
             sb.kind_cnt[xfp_pkg::KIND_BAD_SUM]);
    if (sb.errors == 0 && cfg_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
